FILE: sv/mcab_pkg.sv
// shared types and constants for the multi-connection alternating-bit arq block
// no dependencies; used by the interfaces, the controller, the datapath and the top level
package mcab_pkg;

  localparam int unsigned ADDR_FIELD_W = 32;
  localparam int unsigned OP_W         = 2;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned CONN_W       = 4;

  // operation codes
  localparam logic [OP_W-1:0] OP_SEND    = 2'd0;
  localparam logic [OP_W-1:0] OP_FRAME   = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic take;   // idle, input may be accepted
    logic scan;   // searching the peer table
    logic tread;  // reading the entry named by a timeout
    logic load;   // result goes to the output register, table updated
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            crc_ok;
    logic            ti_ok;
    logic            hit;
    logic            miss;
    logic            out_free;
  } sts_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [CONN_W-1:0]   conn_index;
    logic                send_data;
    logic                data_seq_out;
    logic                start_timer;
    logic                stop_timer;
    logic                send_ack;
    logic                ack_seq_out;
    logic                deliver_up;
    logic                app_disable;
    logic                app_enable;
  } res_t;

endpackage

FILE: sv/mcab_if.sv
// valid/ready channel interfaces for the arq block: event items in, action results out
// depends on mcab_pkg for field widths
interface mcab_item_if;
  logic                                 valid;
  logic                                 ready;
  logic [mcab_pkg::OP_W-1:0]            op;
  logic [mcab_pkg::ADDR_FIELD_W-1:0]    peer_address;
  logic                                 checksum_ok;
  logic                                 has_data;
  logic                                 data_bit;
  logic                                 has_ack;
  logic                                 ack_bit;
  logic [mcab_pkg::CONN_W-1:0]          timeout_index;

  modport source (output valid, op, peer_address, checksum_ok, has_data, data_bit,
                  has_ack, ack_bit, timeout_index, input ready);
  modport sink (input valid, op, peer_address, checksum_ok, has_data, data_bit,
                has_ack, ack_bit, timeout_index, output ready);
endinterface

interface mcab_result_if;
  logic                             valid;
  logic                             ready;
  logic [mcab_pkg::STATUS_W-1:0]    status;
  logic [mcab_pkg::CONN_W-1:0]      conn_index;
  logic                             send_data;
  logic                             data_seq_out;
  logic                             start_timer;
  logic                             stop_timer;
  logic                             send_ack;
  logic                             ack_seq_out;
  logic                             deliver_up;
  logic                             app_disable;
  logic                             app_enable;

  modport source (output valid, status, conn_index, send_data, data_seq_out, start_timer,
                  stop_timer, send_ack, ack_seq_out, deliver_up, app_disable, app_enable,
                  input ready);
  modport sink (input valid, status, conn_index, send_data, data_seq_out, start_timer,
                stop_timer, send_ack, ack_seq_out, deliver_up, app_disable, app_enable,
                output ready);
endinterface

FILE: sv/mcab_ctrl.sv
// controller state machine of the arq block: sequences decode, table search and result load
// depends on mcab_pkg for the command and status structs
module mcab_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mcab_pkg::sts_t sts,
  output mcab_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_SCAN   = 5'b00100,
    S_TREAD  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.op)
          mcab_pkg::OP_SEND:    state_next = S_SCAN;
          mcab_pkg::OP_FRAME:   state_next = sts.crc_ok ? S_SCAN : S_FINISH;
          mcab_pkg::OP_TIMEOUT: state_next = sts.ti_ok ? S_TREAD : S_FINISH;
          default:              state_next = S_IDLE;  // unused op, no result
        endcase
      end
      S_SCAN: begin
        if (sts.hit || sts.miss) state_next = S_FINISH;
      end
      S_TREAD: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign cmd.take  = (state == S_IDLE);
  assign cmd.scan  = (state == S_SCAN);
  assign cmd.tread = (state == S_TREAD);
  assign cmd.load  = (state == S_FINISH) && sts.out_free;

endmodule

FILE: sv/mcab_dp.sv
// datapath of the arq block: item registers, peer table memory, search counter,
// action logic and output register; depends on mcab_pkg
module mcab_dp #(
  parameter int unsigned MAX_CONNECTIONS = 16,
  parameter int unsigned ADDRESS_BITS    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mcab_pkg::cmd_t                      cmd,
  output mcab_pkg::sts_t                      sts,
  input  logic                                in_valid,
  input  logic [mcab_pkg::OP_W-1:0]           in_op,
  input  logic [mcab_pkg::ADDR_FIELD_W-1:0]   in_peer_address,
  input  logic                                in_checksum_ok,
  input  logic                                in_has_data,
  input  logic                                in_data_bit,
  input  logic                                in_has_ack,
  input  logic                                in_ack_bit,
  input  logic [mcab_pkg::CONN_W-1:0]         in_timeout_index,
  output logic                                out_valid,
  input  logic                                out_ready,
  output mcab_pkg::res_t                      res
);

  localparam int unsigned KEY_BITS = (ADDRESS_BITS < mcab_pkg::ADDR_FIELD_W) ?
                                     ADDRESS_BITS : mcab_pkg::ADDR_FIELD_W;
  localparam int unsigned CNT_W    = $clog2(MAX_CONNECTIONS + 1);
  localparam int unsigned IDX_W    = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
  localparam int unsigned CMP_W    = (CNT_W > mcab_pkg::CONN_W) ? CNT_W : mcab_pkg::CONN_W;
  localparam int unsigned ENT_W    = KEY_BITS + 3;

  // entry layout: {key, next send, ack expected, frame expected}
  logic [ENT_W-1:0] mem [MAX_CONNECTIONS];

  logic [mcab_pkg::OP_W-1:0]   op_q;
  logic [KEY_BITS-1:0]         key_q;
  logic                        crc_q, hd_q, db_q, ha_q, ab_q;
  logic [mcab_pkg::CONN_W-1:0] ti_q;

  logic [CNT_W-1:0] open_count;
  logic [CNT_W-1:0] scan;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [ENT_W-1:0] rd_data;
  logic             found;

  logic             ti_ok, scan_more, hit, miss, full, issue;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] cur_idx;
  logic             ns, ae, fe;
  logic             ns_new, ae_new, fe_new;
  logic             we, alloc;
  mcab_pkg::res_t   r;

  assign ti_ok     = CMP_W'(ti_q) < CMP_W'(open_count);
  assign scan_more = scan < open_count;
  assign hit       = rd_vld && (rd_data[ENT_W-1:3] == key_q);
  assign miss      = cmd.scan && !rd_vld && !scan_more;
  assign full      = (open_count == CNT_W'(MAX_CONNECTIONS));
  assign issue     = (cmd.scan && !hit && scan_more) || cmd.tread;
  assign rd_addr   = cmd.tread ? IDX_W'(ti_q) : scan[IDX_W-1:0];

  assign sts.op       = op_q;
  assign sts.crc_ok   = crc_q;
  assign sts.ti_ok    = ti_ok;
  assign sts.hit      = hit;
  assign sts.miss     = miss;
  assign sts.out_free = !out_valid || out_ready;

  // a new entry starts with all sequence bits zero
  assign cur_idx = found ? rd_idx : open_count[IDX_W-1:0];
  assign ns      = found && rd_data[2];
  assign ae      = found && rd_data[1];
  assign fe      = found && rd_data[0];

  always_comb begin
    r      = '0;
    ns_new = ns;
    ae_new = ae;
    fe_new = fe;
    we     = 1'b0;
    alloc  = 1'b0;
    unique case (op_q)
      mcab_pkg::OP_SEND: begin
        if (!found && full) begin
          r.status     = mcab_pkg::ST_FULL;
          r.app_enable = 1'b1;
        end else begin
          r.conn_index   = mcab_pkg::CONN_W'(cur_idx);
          r.send_data    = 1'b1;
          r.data_seq_out = ns;
          r.start_timer  = 1'b1;
          r.app_disable  = 1'b1;
          ns_new         = ~ns;
          we             = 1'b1;
          alloc          = !found;
        end
      end
      mcab_pkg::OP_FRAME: begin
        if (!crc_q) begin
          r.status = mcab_pkg::ST_BAD_CRC;
        end else if (!found && full) begin
          r.status = mcab_pkg::ST_FULL;
        end else begin
          r.conn_index = mcab_pkg::CONN_W'(cur_idx);
          if (ha_q && (ab_q == ae)) begin
            r.stop_timer = 1'b1;
            r.app_enable = 1'b1;
            ae_new       = ~ae;
          end
          if (hd_q) begin
            r.send_ack    = 1'b1;
            r.ack_seq_out = db_q;
            if (db_q == fe) begin
              r.deliver_up = 1'b1;
              fe_new       = ~fe;
            end
          end
          we    = 1'b1;
          alloc = !found;
        end
      end
      mcab_pkg::OP_TIMEOUT: begin
        r.conn_index = ti_q;
        if (!ti_ok) begin
          r.status = mcab_pkg::ST_BAD_INDEX;
        end else begin
          // retransmit carries the last sent bit
          r.send_data    = 1'b1;
          r.data_seq_out = ~rd_data[2];
          r.start_timer  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      open_count <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (cmd.load) begin
        out_valid <= 1'b1;
        if (alloc) open_count <= open_count + CNT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item capture and search bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.take && in_valid) begin
      op_q  <= in_op;
      key_q <= in_peer_address[KEY_BITS-1:0];
      crc_q <= in_checksum_ok;
      hd_q  <= in_has_data;
      db_q  <= in_data_bit;
      ha_q  <= in_has_ack;
      ab_q  <= in_ack_bit;
      ti_q  <= in_timeout_index;
      scan  <= '0;
      found <= 1'b0;
    end else if (cmd.scan) begin
      if (issue) scan <= scan + CNT_W'(1);
      if (hit) found <= 1'b1;
    end
    if (cmd.load) res <= r;
  end

  // peer table, one read and one write port
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[rd_addr];
      rd_idx  <= rd_addr;
    end
    if (cmd.load && we) begin
      mem[cur_idx] <= {key_q, ns_new, ae_new, fe_new};
    end
  end

endmodule

FILE: sv/multi_connection_alternating_bit_arq.sv
// top level of the multi-connection alternating-bit stop-and-wait arq control block
// depends on mcab_pkg, mcab_if (channel interfaces), mcab_ctrl and mcab_dp
//
// usage
//   item:   one event beat per operation: application send, frame arrived or
//           retransmit timeout. a beat moves when valid and ready are both high
//   result: one action beat per send, frame or timeout; the unused op code
//           gives no beat and leaves the table untouched
// sequencing
//   one item is in flight at a time. a timeout reads its entry directly; a
//   bad-checksum frame or a bad timeout index skips the table
//   send and frame items search the peer table linearly through its single
//   read port, one entry a cycle, stopping early when the peer is found
//   the next item is accepted the cycle after the result is loaded, while
//   that result may still sit in the output register
// reset
//   rst is synchronous; it empties the table (open count zero) and drops any
//   pending result. table entries are written when opened before being read
// stall
//   a held result blocks only the next result load; the search stops in its
//   final state and the table is updated in the same cycle the result loads
module multi_connection_alternating_bit_arq #(
  parameter int unsigned MAX_CONNECTIONS = 16,
  parameter int unsigned ADDRESS_BITS    = 32
) (
  input logic              clk,
  input logic              rst,
  mcab_item_if.sink        item,
  mcab_result_if.source    result
);

  mcab_pkg::cmd_t cmd;
  mcab_pkg::sts_t sts;
  mcab_pkg::res_t res;
  logic           out_valid;

  // controller: only command and status cross to the datapath
  mcab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: table memory, search counter, action decode, output register
  mcab_dp #(
    .MAX_CONNECTIONS (MAX_CONNECTIONS),
    .ADDRESS_BITS    (ADDRESS_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_valid         (item.valid),
    .in_op            (item.op),
    .in_peer_address  (item.peer_address),
    .in_checksum_ok   (item.checksum_ok),
    .in_has_data      (item.has_data),
    .in_data_bit      (item.data_bit),
    .in_has_ack       (item.has_ack),
    .in_ack_bit       (item.ack_bit),
    .in_timeout_index (item.timeout_index),
    .out_valid        (out_valid),
    .out_ready        (result.ready),
    .res              (res)
  );

  // input side is open only while the controller is idle
  assign item.ready = cmd.take;

  // result beat straight from the output register
  assign result.valid        = out_valid;
  assign result.status       = res.status;
  assign result.conn_index   = res.conn_index;
  assign result.send_data    = res.send_data;
  assign result.data_seq_out = res.data_seq_out;
  assign result.start_timer  = res.start_timer;
  assign result.stop_timer   = res.stop_timer;
  assign result.send_ack     = res.send_ack;
  assign result.ack_seq_out  = res.ack_seq_out;
  assign result.deliver_up   = res.deliver_up;
  assign result.app_disable  = res.app_disable;
  assign result.app_enable   = res.app_enable;

  // a result load and a new acceptance never share a cycle
  a_take_load_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take && cmd.load))
    else $error("input accepted while a result loads");

  // search ends in exactly one way
  a_hit_miss_excl: assert property (@(posedge clk) disable iff (rst)
    sts.hit |-> !sts.miss)
    else $error("table search reports hit and miss together");

  // a loaded result is offered on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> result.valid)
    else $error("loaded result not offered");

endmodule

FILE: tb/multi_connection_alternating_bit_arq_tb.sv
// self-checking testbench for the multi-connection alternating-bit arq block
// depends on mcab_pkg, the mcab_if channel interfaces and the arq top level
// predicts one action beat per event beat but for the ignored op code, and checks every beat field by field
module multi_connection_alternating_bit_arq_tb;

  localparam int unsigned CONN_SLOTS  = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_WAIT  = 40;   // covers a full-table search and then some

  localparam int unsigned OP_BITS   = mcab_pkg::OP_W;
  localparam int unsigned ADDR_BITS = mcab_pkg::ADDR_FIELD_W;
  localparam int unsigned CONN_BITS = mcab_pkg::CONN_W;

  // op code that the block ignores; the package has no name for it
  localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;

  localparam logic [ADDR_BITS-1:0] ADDR_ZERO = '0;
  localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

  typedef struct packed {
    logic [OP_BITS-1:0]   op;
    logic [ADDR_BITS-1:0] peer_address;
    logic                 checksum_ok;
    logic                 has_data;
    logic                 data_bit;
    logic                 has_ack;
    logic                 ack_bit;
    logic [CONN_BITS-1:0] timeout_index;
  } arq_event_t;

  logic clk;
  logic rst;

  mcab_item_if   item_bus ();
  mcab_result_if result_bus ();

  multi_connection_alternating_bit_arq #(
    .MAX_CONNECTIONS(CONN_SLOTS),
    .ADDRESS_BITS   (ADDR_BITS)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_bus),
    .result(result_bus)
  );

  // shadow copy of the connection table, advanced at each accepted event beat
  logic [ADDR_BITS-1:0] peer_addr    [CONN_SLOTS];
  logic                 next_seq     [CONN_SLOTS];
  logic                 ack_expect   [CONN_SLOTS];
  logic                 frame_expect [CONN_SLOTS];
  int unsigned          peers_open;

  mcab_pkg::res_t pending_actions[$];   // predicted action beats, oldest first

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned idle_pct;      // chance in 100 that the sender sits out a cycle
  int unsigned stall_pct;     // chance in 100 that the receiver holds ready low

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // linear search by address; a miss opens a fresh entry with all bits clear
  // while there is room, otherwise -1 means the table is full
  function automatic int open_or_find(input logic [ADDR_BITS-1:0] addr);
    for (int i = 0; i < peers_open; i++)
      if (peer_addr[i] == addr) return i;
    if (peers_open < CONN_SLOTS) begin
      peer_addr[peers_open]    = addr;
      next_seq[peers_open]     = 1'b0;
      ack_expect[peers_open]   = 1'b0;
      frame_expect[peers_open] = 1'b0;
      peers_open++;
      return peers_open - 1;
    end
    return -1;
  endfunction

  // returns 0 for the ignored op code, which gives no action beat
  function automatic bit predict_actions(input arq_event_t ev,
                                         output mcab_pkg::res_t act);
    int c;
    act = '0;
    if (ev.op == OP_UNUSED) return 1'b0;
    case (ev.op)
      mcab_pkg::OP_SEND: begin
        c = open_or_find(ev.peer_address);
        if (c < 0) begin
          // refused: let the application try again
          act.status     = mcab_pkg::ST_FULL;
          act.app_enable = 1'b1;
        end else begin
          act.conn_index   = c[CONN_BITS-1:0];
          act.send_data    = 1'b1;
          act.data_seq_out = next_seq[c];
          act.start_timer  = 1'b1;
          act.app_disable  = 1'b1;
          next_seq[c]      = ~next_seq[c];
        end
      end
      mcab_pkg::OP_FRAME: begin
        if (!ev.checksum_ok) begin
          // dropped before the table is touched, so no entry gets opened
          act.status = mcab_pkg::ST_BAD_CRC;
        end else begin
          c = open_or_find(ev.peer_address);
          if (c < 0) begin
            act.status = mcab_pkg::ST_FULL;
          end else begin
            act.conn_index = c[CONN_BITS-1:0];
            if (ev.has_ack && ev.ack_bit == ack_expect[c]) begin
              act.stop_timer = 1'b1;
              act.app_enable = 1'b1;
              ack_expect[c]  = ~ack_expect[c];
            end
            if (ev.has_data) begin
              // duplicates are acked again but not passed up
              act.send_ack    = 1'b1;
              act.ack_seq_out = ev.data_bit;
              if (ev.data_bit == frame_expect[c]) begin
                act.deliver_up  = 1'b1;
                frame_expect[c] = ~frame_expect[c];
              end
            end
          end
        end
      end
      default: begin
        act.conn_index = ev.timeout_index;
        if (ev.timeout_index >= peers_open) begin
          act.status = mcab_pkg::ST_BAD_INDEX;
        end else begin
          // retransmit the last bit sent, even with nothing outstanding
          act.send_data    = 1'b1;
          act.data_seq_out = ~next_seq[ev.timeout_index];
          act.start_timer  = 1'b1;
        end
      end
    endcase
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // event beat driver
  // ---------------------------------------------------------------------------

  // called at a falling edge; returns at the falling edge after the beat moved,
  // leaving valid high so a back-to-back beat needs only one assignment
  task automatic send_event(input arq_event_t ev);
    mcab_pkg::res_t act;
    while ($urandom_range(99) < idle_pct) begin
      item_bus.valid <= 1'b0;
      @(negedge clk);
    end
    item_bus.valid         <= 1'b1;
    item_bus.op            <= ev.op;
    item_bus.peer_address  <= ev.peer_address;
    item_bus.checksum_ok   <= ev.checksum_ok;
    item_bus.has_data      <= ev.has_data;
    item_bus.data_bit      <= ev.data_bit;
    item_bus.has_ack       <= ev.has_ack;
    item_bus.ack_bit       <= ev.ack_bit;
    item_bus.timeout_index <= ev.timeout_index;
    do @(posedge clk); while (!item_bus.ready);
    if (predict_actions(ev, act)) pending_actions.push_back(act);
    @(negedge clk);
  endtask

  // drop valid whenever the stimulus stops, or the last beat would repeat
  task automatic bus_quiet();
    item_bus.valid <= 1'b0;
  endtask

  task automatic wait_all_actions();
    while (pending_actions.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic arq_event_t mk_event(input logic [OP_BITS-1:0] op,
                                          input logic [ADDR_BITS-1:0] addr,
                                          input logic ck, input logic hd,
                                          input logic db, input logic ha,
                                          input logic ab,
                                          input logic [CONN_BITS-1:0] ti);
    arq_event_t ev;
    ev.op            = op;
    ev.peer_address  = addr;
    ev.checksum_ok   = ck;
    ev.has_data      = hd;
    ev.data_bit      = db;
    ev.has_ack       = ha;
    ev.ack_bit       = ab;
    ev.timeout_index = ti;
    return ev;
  endfunction

  // mostly a well-behaved peer on an open connection: acks that match what was
  // sent, data in sequence; the rest is stray bits, bad checksums, unknown
  // peers, timeouts on any index and the ignored op code
  function automatic arq_event_t make_random_event();
    arq_event_t ev;
    int unsigned pick;
    int unsigned c;
    ev.op            = OP_BITS'($urandom_range(3));
    ev.peer_address  = $urandom();
    ev.checksum_ok   = 1'($urandom_range(1));
    ev.has_data      = 1'($urandom_range(1));
    ev.data_bit      = 1'($urandom_range(1));
    ev.has_ack       = 1'($urandom_range(1));
    ev.ack_bit       = 1'($urandom_range(1));
    ev.timeout_index = CONN_BITS'($urandom_range(15));
    pick = $urandom_range(99);
    c    = $urandom_range(peers_open - 1);
    if (pick < 30) begin
      ev.op           = mcab_pkg::OP_SEND;
      ev.peer_address = peer_addr[c];
    end else if (pick < 70) begin
      ev.op           = mcab_pkg::OP_FRAME;
      ev.peer_address = peer_addr[c];
      ev.checksum_ok  = ($urandom_range(9) != 0);
      ev.has_ack      = ($urandom_range(9) < 7);
      ev.has_data     = ($urandom_range(9) < 6);
      if ($urandom_range(9) < 8) ev.ack_bit = ack_expect[c];
      if ($urandom_range(3) != 0) ev.data_bit = frame_expect[c];
    end else if (pick < 85) begin
      ev.op = mcab_pkg::OP_TIMEOUT;
      if ($urandom_range(4) != 0) ev.timeout_index = c[CONN_BITS-1:0];
    end else if (pick < 90) begin
      ev.op = OP_UNUSED;
    end else begin
      // unknown peer, refused once the table is full
      ev.op = ($urandom_range(1) != 0) ? mcab_pkg::OP_SEND : mcab_pkg::OP_FRAME;
    end
    return ev;
  endfunction

  // ---------------------------------------------------------------------------
  // action beat receiver and checker
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    result_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    mcab_pkg::res_t want;
    mcab_pkg::res_t got;
    if (!rst && result_bus.valid && result_bus.ready) begin
      got = {result_bus.status, result_bus.conn_index, result_bus.send_data,
             result_bus.data_seq_out, result_bus.start_timer, result_bus.stop_timer,
             result_bus.send_ack, result_bus.ack_seq_out, result_bus.deliver_up,
             result_bus.app_disable, result_bus.app_enable};
      if (pending_actions.size() == 0) begin
        $display("%0t: action beat with nothing expected, expected none, got %h",
                 $time, got);
        mismatch_count++;
      end else begin
        want = pending_actions.pop_front();
        check_field("status",       32'(want.status),       32'(got.status));
        check_field("conn_index",   32'(want.conn_index),   32'(got.conn_index));
        check_field("send_data",    32'(want.send_data),    32'(got.send_data));
        check_field("data_seq_out", 32'(want.data_seq_out), 32'(got.data_seq_out));
        check_field("start_timer",  32'(want.start_timer),  32'(got.start_timer));
        check_field("stop_timer",   32'(want.stop_timer),   32'(got.stop_timer));
        check_field("send_ack",     32'(want.send_ack),     32'(got.send_ack));
        check_field("ack_seq_out",  32'(want.ack_seq_out),  32'(got.ack_seq_out));
        check_field("deliver_up",   32'(want.deliver_up),   32'(got.deliver_up));
        check_field("app_disable",  32'(want.app_disable),  32'(got.app_disable));
        check_field("app_enable",   32'(want.app_enable),   32'(got.app_enable));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // nothing open yet: every timeout index is out of range, bad checksums are
  // dropped without opening an entry, the unused op gives no beat
  task automatic test_empty_table();
    send_event(mk_event(mcab_pkg::OP_TIMEOUT, ADDR_ZERO, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
                        4'd15));
    send_event(mk_event(OP_UNUSED, ADDR_ONES, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd15));
    send_event(mk_event(mcab_pkg::OP_FRAME, ADDR_ZERO, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0,
                        4'd0));
  endtask

  // two peers at the address extremes: send, retransmit, matching and stale
  // acks, in-order and duplicate data, piggybacked ack, an empty frame
  task automatic test_two_peers();
    send_event(mk_event(mcab_pkg::OP_SEND,    ADDR_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));
    send_event(mk_event(mcab_pkg::OP_TIMEOUT, ADDR_ONES, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME,   ADDR_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME,   ADDR_ZERO, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME,   ADDR_ONES, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME,   ADDR_ONES, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME,   ADDR_ONES, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME,   ADDR_ONES, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 4'd0));
    // nothing outstanding on the second peer, still retransmitted
    send_event(mk_event(mcab_pkg::OP_TIMEOUT, ADDR_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd1));
    send_event(mk_event(mcab_pkg::OP_TIMEOUT, ADDR_ZERO, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd2));
  endtask

  // open every entry, then a new peer is refused for a send and for a frame
  task automatic test_table_full();
    while (peers_open < CONN_SLOTS)
      send_event(mk_event(mcab_pkg::OP_SEND, $urandom(), 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          4'd0));
    send_event(mk_event(mcab_pkg::OP_SEND,  32'h5A5A_A5A5, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                        4'd0));
    send_event(mk_event(mcab_pkg::OP_FRAME, 32'hA5A5_5A5A, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                        4'd0));
  endtask

  // random traffic under one idling pattern; halfway through the sender holds
  // off until every action beat has come back
  task automatic test_random_traffic(input int unsigned n_events,
                                     input int unsigned send_idle,
                                     input int unsigned recv_stall);
    int unsigned counted;
    arq_event_t ev;
    counted   = 0;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    while (counted < n_events) begin
      ev = make_random_event();
      send_event(ev);
      if (ev.op != OP_UNUSED) counted++;
      if (counted == n_events / 2 && ev.op != OP_UNUSED) begin
        bus_quiet();
        wait_all_actions();
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    idle_pct               = 0;
    stall_pct              = 0;
    item_bus.valid         = 1'b0;
    item_bus.op            = mcab_pkg::OP_SEND;
    item_bus.peer_address  = '0;
    item_bus.checksum_ok   = 1'b0;
    item_bus.has_data      = 1'b0;
    item_bus.data_bit      = 1'b0;
    item_bus.has_ack       = 1'b0;
    item_bus.ack_bit       = 1'b0;
    item_bus.timeout_index = '0;
    peers_open             = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_two_peers();
    test_table_full();
    test_random_traffic(460, 0, 0);
    test_random_traffic(460, 65, 0);
    test_random_traffic(460, 0, 65);
    test_random_traffic(460, 11, 11);

    bus_quiet();
    wait_all_actions();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_actions.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
